>>> rtl/atpq_pkg.sv
// package for the arrival time priority queue
// holds opcode and status codes, field widths and the sequencer state type
// no dependencies
package atpq_pkg;

   localparam int unsigned OP_W  = 2;
   localparam int unsigned ID_W  = 16;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned CNT_OUT_W = 5;
   localparam int unsigned ST_W  = 2;

   localparam logic [OP_W-1:0] OP_PEEK   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_HEAD,
      S_REM_SHIFT,
      S_FINISH
   } state_type;

endpackage

>>> rtl/arrival_time_priority_queue.sv
// Sorted minimum priority queue of DEPTH track entries (track id plus arrival time),
// earliest arrival at the head, equal times leaving in insertion order. Each request
// peeks, inserts or removes the head and returns one response with the head after the
// operation, the entry count (low five bits) and a status. Entries live in a single
// port-pair memory walked one slot per cycle by one comparator: an insert scans from
// the tail, shifting larger keys up, a remove shifts every entry down one slot, and
// peek and the refused or empty cases need no walk. A new request is taken once the
// previous response is loaded into the output register, even while it still waits
// there.
// depends on atpq_pkg
module arrival_time_priority_queue
   import atpq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [ID_W-1:0]       req_track_id,
   input  logic [KEY_W-1:0]      req_arrival_time,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_head_valid,
   output logic [ID_W-1:0]       rsp_head_track_id,
   output logic [KEY_W-1:0]      rsp_head_arrival_time,
   output logic [CNT_OUT_W-1:0]  rsp_entry_count,
   output logic [ST_W-1:0]       rsp_status
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   // entry memory
   logic [KEY_W-1:0] key_mem [DEPTH];
   logic [ID_W-1:0]  id_mem  [DEPTH];

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] wr_key;
   logic [ID_W-1:0]  wr_id;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [KEY_W-1:0] rd_key_ff;
   logic [ID_W-1:0]  rd_id_ff;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [ST_W-1:0]  status_ff, status_in;
   logic [KEY_W-1:0] head_key_ff, head_key_in;
   logic [ID_W-1:0]  head_id_ff, head_id_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_head_valid_ff;
   logic [ID_W-1:0]      rsp_head_id_ff;
   logic [KEY_W-1:0]     rsp_head_key_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff;
   logic [ST_W-1:0]      rsp_status_ff;
   logic                 rsp_load;

   logic [IDX_W-1:0]     last_idx;
   logic [IDX_W-1:0]     ptr_up;
   logic [IDX_W-1:0]     ptr_dn;
   logic [CNT_W+CNT_OUT_W-1:0] fill_wide;

   assign last_idx  = IDX_W'(fill_ff - CNT_W'(1));
   assign ptr_up    = ptr_ff + IDX_W'(1);
   assign ptr_dn    = ptr_ff - IDX_W'(1);
   assign fill_wide = {{CNT_OUT_W{1'b0}}, fill_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         id_mem[wr_addr]  <= wr_id;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_id_ff  <= id_mem[rd_addr];
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      fill_in     = fill_ff;
      key_in      = key_ff;
      id_in       = id_ff;
      status_in   = status_ff;
      head_key_in = head_key_ff;
      head_id_in  = head_id_ff;
      wr_en       = 1'b0;
      wr_addr     = ptr_up;
      wr_key      = key_ff;
      wr_id       = id_ff;
      rd_en       = 1'b0;
      rd_addr     = ptr_dn;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in    = req_arrival_time;
               id_in     = req_track_id;
               status_in = ST_OK;
               state_in  = S_FINISH;
               unique case (req_opcode)
                  OP_INSERT: begin
                     if (fill_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else if (fill_ff == '0) begin
                        wr_en       = 1'b1;
                        wr_addr     = '0;
                        wr_key      = req_arrival_time;
                        wr_id       = req_track_id;
                        head_key_in = req_arrival_time;
                        head_id_in  = req_track_id;
                        fill_in     = CNT_W'(1);
                     end else begin
                        // scan from the tail toward the head
                        rd_en    = 1'b1;
                        rd_addr  = last_idx;
                        ptr_in   = last_idx;
                        state_in = S_INS_CMP;
                     end
                  end
                  OP_REMOVE: begin
                     if (fill_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (fill_ff == CNT_W'(1)) begin
                        fill_in = '0;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(1);
                        ptr_in   = IDX_W'(1);
                        state_in = S_REM_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_CMP: begin
            // strictly greater moves up, so equal keys stay ahead of the new one
            if (rd_key_ff > key_ff) begin
               wr_en  = 1'b1;
               wr_key = rd_key_ff;
               wr_id  = rd_id_ff;
               if (ptr_ff == '0) begin
                  state_in = S_INS_HEAD;
               end else begin
                  rd_en  = 1'b1;
                  ptr_in = ptr_dn;
               end
            end else begin
               wr_en    = 1'b1;
               fill_in  = fill_ff + CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_INS_HEAD: begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            head_key_in = key_ff;
            head_id_in  = id_ff;
            fill_in     = fill_ff + CNT_W'(1);
            state_in    = S_FINISH;
         end
         S_REM_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_dn;
            wr_key  = rd_key_ff;
            wr_id   = rd_id_ff;
            if (ptr_ff == IDX_W'(1)) begin
               head_key_in = rd_key_ff;
               head_id_in  = rd_id_ff;
            end
            if (ptr_ff == last_idx) begin
               fill_in  = fill_ff - CNT_W'(1);
               state_in = S_FINISH;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_up;
               ptr_in  = ptr_up;
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      key_ff      <= key_in;
      id_ff       <= id_in;
      status_ff   <= status_in;
      head_key_ff <= head_key_in;
      head_id_ff  <= head_id_in;
      if (rsp_load) begin
         rsp_head_valid_ff <= (fill_ff != '0);
         rsp_head_id_ff    <= (fill_ff != '0) ? head_id_ff : '0;
         rsp_head_key_ff   <= (fill_ff != '0) ? head_key_ff : '0;
         rsp_count_ff      <= fill_wide[CNT_OUT_W-1:0];
         rsp_status_ff     <= status_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_head_valid        = rsp_head_valid_ff;
   assign rsp_head_track_id     = rsp_head_id_ff;
   assign rsp_head_arrival_time = rsp_head_key_ff;
   assign rsp_entry_count       = rsp_count_ff;
   assign rsp_status            = rsp_status_ff;

endmodule

>>> tb/atpq_order_checker.sv
// request/response checker for the arrival time priority queue
// keeps its own sorted copy of the queue and compares every response with it
// depends on atpq_pkg
module atpq_order_checker
   import atpq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [ID_W-1:0]       req_track_id,
   input  logic [KEY_W-1:0]      req_arrival_time,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_head_valid,
   input  logic [ID_W-1:0]       rsp_head_track_id,
   input  logic [KEY_W-1:0]      rsp_head_arrival_time,
   input  logic [CNT_OUT_W-1:0]  rsp_entry_count,
   input  logic [ST_W-1:0]       rsp_status,
   output int                    mismatches,
   output int                    pending,
   output int                    checked,
   output int                    refused_inserts,
   output int                    empty_removes
);

   typedef struct packed {
      logic                  head_valid;
      logic [ID_W-1:0]       head_id;
      logic [KEY_W-1:0]      head_key;
      logic [CNT_OUT_W-1:0]  count;
      logic [ST_W-1:0]       status;
   } head_report_type;

   logic [KEY_W-1:0]   slot_key [DEPTH];
   logic [ID_W-1:0]    slot_id  [DEPTH];
   int                 held;
   head_report_type    expected_heads [$];

   initial begin
      mismatches = 0;
      pending = 0;
      checked = 0;
      refused_inserts = 0;
      empty_removes = 0;
      held = 0;
   end

   // applies one request to the local queue and returns the response it should give
   function automatic head_report_type apply_request(input logic [OP_W-1:0] op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [KEY_W-1:0] key);
      head_report_type r;
      int pos;
      int i;
      r = '0;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
         if (held >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // go behind every entry with an equal time
            pos = 0;
            while (pos < held && slot_key[pos] <= key) pos++;
            for (i = held; i > pos; i--) begin
               slot_key[i] = slot_key[i-1];
               slot_id[i] = slot_id[i-1];
            end
            slot_key[pos] = key;
            slot_id[pos] = id;
            held++;
         end
      end else if (op == OP_REMOVE) begin
         if (held == 0) begin
            r.status = ST_EMPTY;
         end else begin
            for (i = 1; i < held; i++) begin
               slot_key[i-1] = slot_key[i];
               slot_id[i-1] = slot_id[i];
            end
            held--;
         end
      end
      if (held > 0) begin
         r.head_valid = 1'b1;
         r.head_id = slot_id[0];
         r.head_key = slot_key[0];
      end
      r.count = CNT_OUT_W'(held);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      head_report_type want;
      head_report_type fresh;
      if (reset) begin
         held = 0;
         expected_heads.delete();
      end else begin
         // the response register means a response never belongs to this edge's request
         if (rsp_valid && rsp_ready) begin
            if (expected_heads.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: response with no request waiting: valid %0b id %h time %h",
                           rsp_head_valid, rsp_head_track_id, rsp_head_arrival_time);
                  $display("  count %0d status %0d", rsp_entry_count, rsp_status);
               end
            end else begin
               want = expected_heads.pop_front();
               checked++;
               if (want.status == ST_FULL) refused_inserts++;
               if (want.status == ST_EMPTY) empty_removes++;
               if (rsp_head_valid !== want.head_valid || rsp_head_track_id !== want.head_id ||
                   rsp_head_arrival_time !== want.head_key || rsp_entry_count !== want.count ||
                   rsp_status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch on response %0d at %0t", checked, $realtime);
                     $display("  expected: valid %0b id %h time %h count %0d status %0d",
                              want.head_valid, want.head_id, want.head_key, want.count,
                              want.status);
                     $display("  actual:   valid %0b id %h time %h count %0d status %0d",
                              rsp_head_valid, rsp_head_track_id, rsp_head_arrival_time,
                              rsp_entry_count, rsp_status);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh = apply_request(req_opcode, req_track_id, req_arrival_time);
            expected_heads.insert(expected_heads.size(), fresh);
         end
      end
      pending <= expected_heads.size();
   end

endmodule

>>> tb/tb_arrival_time_priority_queue.sv
// testbench top for the arrival time priority queue: clock, reset, request
// stimulus with random gaps, response back-pressure and the final verdict
// depends on atpq_pkg, arrival_time_priority_queue and atpq_order_checker
module tb_arrival_time_priority_queue;
   import atpq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_opcode;
   logic [ID_W-1:0]       req_track_id;
   logic [KEY_W-1:0]      req_arrival_time;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_head_valid;
   logic [ID_W-1:0]       rsp_head_track_id;
   logic [KEY_W-1:0]      rsp_head_arrival_time;
   logic [CNT_OUT_W-1:0]  rsp_entry_count;
   logic [ST_W-1:0]       rsp_status;

   int  mismatches;
   int  pending;
   int  checked;
   int  refused_inserts;
   int  empty_removes;
   int  requests_sent;
   logic calm;

   arrival_time_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_track_id(req_track_id),
      .req_arrival_time(req_arrival_time),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_head_valid(rsp_head_valid),
      .rsp_head_track_id(rsp_head_track_id),
      .rsp_head_arrival_time(rsp_head_arrival_time),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   atpq_order_checker #(.DEPTH(QUEUE_DEPTH)) order_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_track_id(req_track_id),
      .req_arrival_time(req_arrival_time),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_head_valid(rsp_head_valid),
      .rsp_head_track_id(rsp_head_track_id),
      .rsp_head_arrival_time(rsp_head_arrival_time),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status),
      .mismatches(mismatches),
      .pending(pending),
      .checked(checked),
      .refused_inserts(refused_inserts),
      .empty_removes(empty_removes)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 37);
      end
   end

   // many ties from a tiny range, some extremes, the rest anywhere
   function automatic logic [KEY_W-1:0] pick_arrival_time();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return KEY_W'($urandom_range(7));
      if (roll < 45) return '0;
      if (roll < 50) return '1;
      return KEY_W'($urandom);
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input logic [KEY_W-1:0] key);
      if (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_track_id <= id;
      req_arrival_time <= key;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // hold off until every response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      logic [OP_W-1:0] op;
      int mode;
      int burst;
      int roll;
      int sent_random;
      int i;
      requests_sent = 0;
      sent_random = 0;
      calm <= 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_PEEK;
      req_track_id <= '0;
      req_arrival_time <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty queue corners
      send_request(OP_REMOVE, 16'hA5A5, 32'h5A5A_5A5A);
      send_request(OP_PEEK, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(OP_UNUSED, 16'h1234, 32'hDEAD_BEEF);
      // field extremes, then equal times that must leave in arrival order
      send_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 16'h0000, 32'h0000_0000);
      send_request(OP_INSERT, 16'h0A0A, 32'h8000_0000);
      send_request(OP_INSERT, 16'h0B0B, 32'h8000_0000);
      send_request(OP_INSERT, 16'h0C0C, 32'h8000_0000);
      send_request(OP_INSERT, 16'h1234, 32'h0000_0000);
      for (i = 0; i < 11; i++) send_request(OP_INSERT, ID_W'($urandom), pick_arrival_time());
      // full queue refuses the insert
      send_request(OP_INSERT, 16'h5555, 32'h0000_0000);
      send_request(OP_PEEK, ID_W'($urandom), KEY_W'($urandom));
      for (i = 0; i < 3; i++) send_request(OP_REMOVE, ID_W'($urandom), KEY_W'($urandom));
      wait_for_drain();

      // bursts that lean toward filling, draining or neither, so full and empty recur
      while (sent_random < RANDOM_ITEMS) begin
         mode = $urandom_range(2);
         burst = $urandom_range(10, 40);
         for (i = 0; i < burst && sent_random < RANDOM_ITEMS; i++) begin
            roll = $urandom_range(99);
            case (mode)
               0: begin
                  op = roll < 75 ? OP_INSERT : roll < 88 ? OP_REMOVE :
                       roll < 96 ? OP_PEEK : OP_UNUSED;
               end
               1: begin
                  op = roll < 75 ? OP_REMOVE : roll < 88 ? OP_INSERT :
                       roll < 96 ? OP_PEEK : OP_UNUSED;
               end
               default: begin
                  op = roll < 45 ? OP_INSERT : roll < 90 ? OP_REMOVE :
                       roll < 97 ? OP_PEEK : OP_UNUSED;
               end
            endcase
            send_request(op, ID_W'($urandom),
                         op == OP_INSERT ? pick_arrival_time() : KEY_W'($urandom));
            sent_random++;
            // one stretch with no gaps and no stalls on either side
            calm <= (sent_random >= 250 && sent_random < 350);
            if (sent_random % 120 == 0) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests in fill, drain and mixed bursts; %0d responses checked",
               requests_sent, checked);
      $display("%0d inserts refused on a full queue, %0d removes on an empty one",
               refused_inserts, empty_removes);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS arrival_time_priority_queue");
      end else begin
         $display("FAIL arrival_time_priority_queue");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL arrival_time_priority_queue");
      $finish;
   end

endmodule

>>> sim.f
rtl/atpq_pkg.sv
rtl/arrival_time_priority_queue.sv
tb/atpq_order_checker.sv
tb/tb_arrival_time_priority_queue.sv
